// File: rtl/rls_pkg.sv
// Shared types and constants for the RGB 3x3 Laplacian sharpening block.
// Holds the register map, the pixel and result record types, and the result
// queue sizing. No dependencies.
`default_nettype none

package rls_pkg;

    // Configuration register map (register index = paddr[3:2]).
    localparam int ADDR_W    = 4;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SHARPEN_ENABLE = 2'd2;

    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 13;

    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST    = 11'd640;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST   = 13'd480;
    localparam logic                      SHARPEN_ENABLE_RST = 1'b1;

    // Output tag widths.
    localparam int OUT_COL_W = 10;
    localparam int OUT_ROW_W = 12;

    localparam logic [7:0] WHITE = 8'd255;

    // Which results a pixel causes, one bit each, in output order.
    localparam int RES_W        = 3;
    localparam int RES_CENTER   = 0;
    localparam int RES_LAST_COL = 1;
    localparam int RES_LAST_ROW = 2;

    // Result queue.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    // One queue entry holds every result caused by one input pixel.
    typedef struct packed {
        pixel_t               rgb;
        logic [OUT_COL_W-1:0] col;
        logic [OUT_ROW_W-1:0] row;
        logic [RES_W-1:0]     flags;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/rls_if.sv
// Valid/ready stream interfaces for the pixel input and the result output.
// Depends on nothing; payload fields follow the block's item definitions.
`default_nettype none

interface rls_pix_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

interface rls_pix_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [9:0]  out_column;
    logic [11:0] out_row;
    logic        run_last;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output out_column, output out_row, output run_last,
                    input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input out_column, input out_row, input run_last,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/rls_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module rls_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/rls_filter.sv
// Laplacian sharpening arithmetic for one 3x3 RGB window, all three channels.
// Depends on rls_pkg for the pixel type.
`default_nettype none

module rls_filter (
    input  rls_pkg::pixel_t win [9],
    input  logic            sharpen,
    output rls_pkg::pixel_t result
);

    logic [23:0] res_bits;

    // centre + (8*centre - neighbours) = 9*centre - neighbours, clamped to 0..255; centre if !sharpen.
    always_comb
    begin
        logic [10:0]        nsum;
        logic [7:0]         centre;
        logic signed [12:0] v;
        res_bits = '0;
        for (int k = 0; k < 3; k++)
        begin
            nsum = '0;
            for (int i = 0; i < 9; i++)
            begin
                if (i != 4)
                begin
                    nsum = nsum + 11'(win[i][8*k +: 8]);
                end
            end
            centre = win[4][8*k +: 8];
            if (sharpen)
            begin
                v = $signed({2'b00, centre, 3'b000}) + $signed({5'b00000, centre})
                    - $signed({2'b00, nsum});
            end
            else
            begin
                v = $signed({5'b00000, centre});
            end
            if (v < 0)
            begin
                res_bits[8*k +: 8] = 8'd0;
            end
            else if (v > 13'sd255)
            begin
                res_bits[8*k +: 8] = rls_pkg::WHITE;
            end
            else
            begin
                res_bits[8*k +: 8] = v[7:0];
            end
        end
    end

    assign result = res_bits;

endmodule

`default_nettype wire

// File: rtl/rgb_laplacian_sharpen_3x3_top.sv
// RGB 3x3 Laplacian sharpening filter, top level. Uses rls_pkg, rls_if, rls_ram, rls_filter.
// Path: a pixel's first result is offered once stage 1, the window update with stage 2,
//   and the filter into the queue have registered it; it can leave on an output handshake.
// Throughput: one pixel per cycle while pix_in.ready is high; a last-column or last-row
//   pixel gives up to three results, and a four-entry result queue decouples the two sides.
// Reset: rst_n is asynchronous, active low; registers load 640, 480, 1; line stores keep data.
`default_nettype none

module rgb_laplacian_sharpen_3x3_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rls_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    rls_pix_in_if.sink                 pix_in,
    rls_pix_out_if.source              pix_out
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int OCC_W = rls_pkg::FIFO_AW + 2;

    function automatic logic [CW-1:0] last_col(input logic [rls_pkg::FRAME_WIDTH_W-1:0] v);
        int lim;
        begin
            lim = int'(v);
            if (lim < 3)
            begin
                lim = 3;
            end
            if (lim > MAX_WIDTH)
            begin
                lim = MAX_WIDTH;
            end
            return CW'(lim - 1);
        end
    endfunction

    function automatic logic [RW-1:0] last_row(input logic [rls_pkg::FRAME_HEIGHT_W-1:0] v);
        int lim;
        begin
            lim = int'(v);
            if (lim < 3)
            begin
                lim = 3;
            end
            if (lim > MAX_HEIGHT)
            begin
                lim = MAX_HEIGHT;
            end
            return RW'(lim - 1);
        end
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [rls_pkg::FRAME_WIDTH_W-1:0]  frame_width_reg;
    logic [rls_pkg::FRAME_HEIGHT_W-1:0] frame_height_reg;
    logic                               sharpen_reg;
    logic [CW-1:0]                      wlast_reg;
    logic [RW-1:0]                      hlast_reg;
    logic                               cfg_wr;
    logic                               cfg_hit;
    logic [rls_pkg::REG_IDX_W-1:0]      reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[rls_pkg::ADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_hit = (reg_idx == rls_pkg::REG_FRAME_WIDTH)
                  || (reg_idx == rls_pkg::REG_FRAME_HEIGHT)
                  || (reg_idx == rls_pkg::REG_SHARPEN_ENABLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= rls_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= rls_pkg::FRAME_HEIGHT_RST;
            sharpen_reg      <= rls_pkg::SHARPEN_ENABLE_RST;
            wlast_reg        <= last_col(rls_pkg::FRAME_WIDTH_RST);
            hlast_reg        <= last_row(rls_pkg::FRAME_HEIGHT_RST);
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                rls_pkg::REG_FRAME_WIDTH:
                begin
                    frame_width_reg <= pwdata[rls_pkg::FRAME_WIDTH_W-1:0];
                    wlast_reg       <= last_col(pwdata[rls_pkg::FRAME_WIDTH_W-1:0]);
                end
                rls_pkg::REG_FRAME_HEIGHT:
                begin
                    frame_height_reg <= pwdata[rls_pkg::FRAME_HEIGHT_W-1:0];
                    hlast_reg        <= last_row(pwdata[rls_pkg::FRAME_HEIGHT_W-1:0]);
                end
                rls_pkg::REG_SHARPEN_ENABLE:
                begin
                    sharpen_reg <= pwdata[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            rls_pkg::REG_FRAME_WIDTH:    prdata = 32'(frame_width_reg);
            rls_pkg::REG_FRAME_HEIGHT:   prdata = 32'(frame_height_reg);
            rls_pkg::REG_SHARPEN_ENABLE: prdata = 32'(sharpen_reg);
            default:                     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Raster position counters and accept stage
    // ------------------------------------------------------------------
    logic                                   in_accept;
    logic [CW-1:0]                          col_reg;
    logic [RW-1:0]                          row_reg;
    logic [rls_pkg::RES_W-1:0]              flags;
    logic                                   interior;
    logic [rls_pkg::FIFO_AW:0]              count_reg;
    logic                                   s1_valid_reg;
    logic                                   s2_valid_reg;
    logic [OCC_W-1:0]                       occ;

    // Accepted pixels hold a queue slot until popped, or through stage 2 if not pushed.
    assign occ          = OCC_W'(count_reg) + OCC_W'(s1_valid_reg) + OCC_W'(s2_valid_reg);
    assign pix_in.ready = occ < OCC_W'(rls_pkg::FIFO_DEPTH);
    assign in_accept    = pix_in.valid & pix_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_wr && cfg_hit)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_accept)
        begin
            if (col_reg == wlast_reg)
            begin
                col_reg <= '0;
                row_reg <= (row_reg == hlast_reg) ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    always_comb
    begin
        flags                       = '0;
        flags[rls_pkg::RES_CENTER]  = (row_reg != '0) && (col_reg != '0);
        flags[rls_pkg::RES_LAST_COL] = (row_reg != '0) && (col_reg == wlast_reg);
        flags[rls_pkg::RES_LAST_ROW] = (row_reg == hlast_reg);
        interior                    = (|row_reg[RW-1:1]) && (|col_reg[CW-1:1]);
    end

    // ------------------------------------------------------------------
    // Stage 1: line store read data arrives, stores are rewritten
    // ------------------------------------------------------------------
    rls_pkg::result_t s1_entry_reg;
    logic [CW-1:0]    s1_col_reg;
    logic             s1_interior_reg;
    logic [23:0]      prev_rd;
    logic [23:0]      older_rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_entry_reg.rgb.red   <= pix_in.red_in;
            s1_entry_reg.rgb.green <= pix_in.green_in;
            s1_entry_reg.rgb.blue  <= pix_in.blue_in;
            s1_entry_reg.col       <= rls_pkg::OUT_COL_W'(col_reg);
            s1_entry_reg.row       <= rls_pkg::OUT_ROW_W'(row_reg);
            s1_entry_reg.flags     <= flags;
            s1_col_reg             <= col_reg;
            s1_interior_reg        <= interior;
        end
    end

    // The row above moves into the older store as the new pixel replaces it.
    rls_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_line_prev (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (s1_entry_reg.rgb),
        .rd_en   (in_accept),
        .rd_addr (col_reg),
        .rd_data (prev_rd)
    );

    rls_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_line_older (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (prev_rd),
        .rd_en   (in_accept),
        .rd_addr (col_reg),
        .rd_data (older_rd)
    );

    // ------------------------------------------------------------------
    // Window shift and stage 2
    // ------------------------------------------------------------------
    rls_pkg::pixel_t  win_reg [9];
    rls_pkg::result_t s2_entry_reg;
    logic             s2_interior_reg;
    rls_pkg::pixel_t  filt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_valid_reg)
        begin
            for (int j = 0; j < 3; j++)
            begin
                win_reg[3*j]     <= win_reg[3*j + 1];
                win_reg[3*j + 1] <= win_reg[3*j + 2];
            end
            win_reg[2] <= older_rd;
            win_reg[5] <= prev_rd;
            win_reg[8] <= s1_entry_reg.rgb;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_entry_reg    <= s1_entry_reg;
            s2_interior_reg <= s1_interior_reg;
        end
    end

    rls_filter u_filter (
        .win     (win_reg),
        .sharpen (sharpen_reg),
        .result  (filt)
    );

    // ------------------------------------------------------------------
    // Result queue: one entry per pixel that causes any result
    // ------------------------------------------------------------------
    rls_pkg::result_t              fifo_mem [rls_pkg::FIFO_DEPTH];
    rls_pkg::result_t              push_entry;
    rls_pkg::result_t              head;
    logic [rls_pkg::FIFO_AW-1:0]   wr_ptr_reg;
    logic [rls_pkg::FIFO_AW-1:0]   rd_ptr_reg;
    logic [rls_pkg::RES_W-1:0]     done_reg;
    logic [rls_pkg::RES_W-1:0]     rem;
    logic [rls_pkg::RES_W-1:0]     sel_mask;
    logic                          push;
    logic                          pop;
    logic                          out_take;
    logic                          res_last;

    always_comb
    begin
        push_entry     = s2_entry_reg;
        push_entry.rgb = s2_interior_reg ? filt
                                         : {rls_pkg::WHITE, rls_pkg::WHITE, rls_pkg::WHITE};
    end

    assign push = s2_valid_reg && (s2_entry_reg.flags != '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= push_entry;
        end
    end

    assign head = fifo_mem[rd_ptr_reg];
    assign rem  = head.flags & ~done_reg;

    always_comb
    begin
        if (rem[rls_pkg::RES_CENTER])
        begin
            sel_mask = rls_pkg::RES_W'(1) << rls_pkg::RES_CENTER;
        end
        else if (rem[rls_pkg::RES_LAST_COL])
        begin
            sel_mask = rls_pkg::RES_W'(1) << rls_pkg::RES_LAST_COL;
        end
        else
        begin
            sel_mask = rls_pkg::RES_W'(1) << rls_pkg::RES_LAST_ROW;
        end
    end

    assign res_last = (rem & ~sel_mask) == '0;
    assign out_take = pix_out.valid & pix_out.ready;
    assign pop      = out_take & res_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            done_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + rls_pkg::FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + rls_pkg::FIFO_AW'(1);
            end
            count_reg <= count_reg + (rls_pkg::FIFO_AW + 1)'(push)
                                   - (rls_pkg::FIFO_AW + 1)'(pop);
            if (pop)
            begin
                done_reg <= '0;
            end
            else if (out_take)
            begin
                done_reg <= done_reg | sel_mask;
            end
        end
    end

    // The centre result is tagged one column and one row back; edge results
    // keep the column, and only the last-row result keeps the row.
    assign pix_out.valid      = count_reg != '0;
    assign pix_out.red_out    = sel_mask[rls_pkg::RES_CENTER] ? head.rgb.red   : rls_pkg::WHITE;
    assign pix_out.green_out  = sel_mask[rls_pkg::RES_CENTER] ? head.rgb.green : rls_pkg::WHITE;
    assign pix_out.blue_out   = sel_mask[rls_pkg::RES_CENTER] ? head.rgb.blue  : rls_pkg::WHITE;
    assign pix_out.out_column = sel_mask[rls_pkg::RES_CENTER]
                              ? head.col - rls_pkg::OUT_COL_W'(1) : head.col;
    assign pix_out.out_row    = sel_mask[rls_pkg::RES_LAST_ROW]
                              ? head.row : head.row - rls_pkg::OUT_ROW_W'(1);
    assign pix_out.run_last   = res_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ <= OCC_W'(rls_pkg::FIFO_DEPTH))
        else $error("pixels in flight exceed the result queue depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < (rls_pkg::FIFO_AW + 1)'(rls_pkg::FIFO_DEPTH)) || pop)
        else $error("result queue written while full");

    a_head_pending: assert property (@(posedge clk) disable iff (!rst_n)
        pix_out.valid |-> rem != '0)
        else $error("queue head offered with no result left");

    a_stage_source: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $past(in_accept))
        else $error("stage 1 holds a pixel that was never accepted");

endmodule

`default_nettype wire
